FILE: hw/rtl/rstl_pkg.sv
// ----------------------------------------------------------------------------
// rstl_pkg - shared types and constants for the reverse suffix trie lookup
// Node pool sizing, alphabet folding, opcode/status codes, trie entry layout.
// ----------------------------------------------------------------------------
package rstl_pkg;

	localparam int NODE_COUNT    = 1024;
	localparam int ALPHABET_SIZE = 37;
	localparam int LETTER_COUNT  = 26;
	localparam int DOT_CODE      = 36;

	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int CNT_W      = $clog2(NODE_COUNT + 1);
	localparam int SLOT_COUNT = NODE_COUNT * ALPHABET_SIZE;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int CODE_W     = $clog2(ALPHABET_SIZE);
	localparam int TYPE_W     = 8;

	typedef enum logic [1:0] {
		OP_INS_CHAR = 2'd0,
		OP_INS_END  = 2'd1,
		OP_LK_CHAR  = 2'd2,
		OP_LK_END   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_TYPED   = 3'd2,
		ST_FULL    = 3'd3,
		ST_NONE    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ
	} state_t;

	typedef struct packed {
		logic              typed;
		logic [TYPE_W-1:0] tid;
	} typ_t;

	// one child link; carries the child's own type so a walk needs one read
	typedef struct packed {
		typ_t              typ;
		logic [NODE_W-1:0] child;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] addr;
		entry_t            wdata;
	} mem_req_t;

	typedef struct packed {
		logic              valid;
		status_t           status;
		logic [TYPE_W-1:0] rtype;
	} res_t;

	typedef struct packed {
		logic              valid;
		logic [CODE_W-1:0] code;
	} fold_t;

	function automatic fold_t fold_char(input logic [7:0] c);
		fold_t f;
		f.valid = 1'b1;
		f.code  = '0;
		if (c >= 8'h61 && c <= 8'h7a) begin
			f.code = CODE_W'(c - 8'h61);
		end else if (c >= 8'h41 && c <= 8'h5a) begin
			f.code = CODE_W'(c - 8'h41);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			f.code = CODE_W'(c - 8'h30) + CODE_W'(LETTER_COUNT);
		end else if (c == 8'h2e) begin
			f.code = CODE_W'(DOT_CODE);
		end else begin
			f.valid = 1'b0;
		end
		return f;
	endfunction

endpackage

FILE: hw/rtl/rstl_ram.sv
// ----------------------------------------------------------------------------
// rstl_ram - generic single-port synchronous RAM
// One read or write per cycle, registered read data (read-first).
// ----------------------------------------------------------------------------
module rstl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: hw/rtl/rstl_ctrl.sv
// ----------------------------------------------------------------------------
// rstl_ctrl - trie walk sequencer
// Clears the child table after reset, then runs insert/lookup walks with one
// table read per character and a write-back on allocation or typing.
// ----------------------------------------------------------------------------
module rstl_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  logic [1:0]                operation,
	input  logic [7:0]                character,
	input  logic [7:0]                type_id,
	input  logic                      out_free,
	output rstl_pkg::res_t            res,
	output rstl_pkg::mem_req_t        mem_req,
	input  rstl_pkg::entry_t          mem_rd
);

	rstl_pkg::state_t                 state_q, state_d;
	logic [rstl_pkg::SLOT_W-1:0]      clr_q;
	logic [rstl_pkg::NODE_W-1:0]      cursor_q;
	rstl_pkg::typ_t                   cur_type_q;
	logic [rstl_pkg::SLOT_W-1:0]      slot_q;
	rstl_pkg::typ_t                   best_q;
	logic                             stopped_q;
	rstl_pkg::status_t                pend_q;
	rstl_pkg::typ_t                   root_type_q;
	logic [rstl_pkg::CNT_W-1:0]       niu_q;
	rstl_pkg::op_t                    op_s1;
	logic [rstl_pkg::SLOT_W-1:0]      slot_s1;

	rstl_pkg::op_t                    op;
	rstl_pkg::fold_t                  fold;
	logic                             is_end;
	logic                             acc;
	logic                             skip;
	logic                             rd_go;
	logic                             miss;
	logic                             full;
	logic                             alloc;
	logic                             at_root;
	logic                             type_wr;
	logic [rstl_pkg::SLOT_W-1:0]      slot_new;

	assign op       = rstl_pkg::op_t'(operation);
	assign fold     = rstl_pkg::fold_char(character);
	assign is_end   = (op == rstl_pkg::OP_INS_END) || (op == rstl_pkg::OP_LK_END);
	assign acc      = cmd_valid && cmd_ready;
	assign skip     = (pend_q != rstl_pkg::ST_OK) || (op == rstl_pkg::OP_LK_CHAR && stopped_q);
	assign rd_go    = acc && !is_end && !skip && fold.valid;
	assign slot_new = rstl_pkg::SLOT_W'(cursor_q) * rstl_pkg::SLOT_W'(rstl_pkg::ALPHABET_SIZE)
	                + rstl_pkg::SLOT_W'(fold.code);
	assign miss     = (mem_rd.child == '0);
	assign full     = (niu_q >= rstl_pkg::CNT_W'(rstl_pkg::NODE_COUNT));
	assign alloc    = (state_q == rstl_pkg::S_READ) && (op_s1 == rstl_pkg::OP_INS_CHAR)
	                && miss && !full;
	assign at_root  = (cursor_q == '0);
	// typing a non-root node rewrites the link that led to it
	assign type_wr  = acc && (op == rstl_pkg::OP_INS_END) && (pend_q == rstl_pkg::ST_OK)
	                && !at_root && !cur_type_q.typed;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rstl_pkg::S_CLEAR: begin
				if (clr_q == rstl_pkg::SLOT_W'(rstl_pkg::SLOT_COUNT - 1)) begin
					state_d = rstl_pkg::S_IDLE;
				end
			end
			rstl_pkg::S_IDLE: begin
				if (rd_go) begin
					state_d = rstl_pkg::S_READ;
				end
			end
			rstl_pkg::S_READ: begin
				state_d = rstl_pkg::S_IDLE;
			end
			default: state_d = rstl_pkg::S_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd_ready     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.addr  = slot_q;
		mem_req.wdata = '0;
		unique case (state_q)
			rstl_pkg::S_CLEAR: begin
				mem_req.we   = 1'b1;
				mem_req.addr = clr_q;
			end
			rstl_pkg::S_IDLE: begin
				// an end word needs room in the output register
				cmd_ready = !is_end || out_free;
				if (rd_go) begin
					mem_req.addr = slot_new;
				end
				mem_req.we              = type_wr;
				mem_req.wdata.typ.typed = 1'b1;
				mem_req.wdata.typ.tid   = type_id;
				mem_req.wdata.child     = cursor_q;
			end
			rstl_pkg::S_READ: begin
				mem_req.we          = alloc;
				mem_req.addr        = slot_s1;
				mem_req.wdata.child = niu_q[rstl_pkg::NODE_W-1:0];
			end
			default: ;
		endcase
	end

	// end-step result
	always_comb begin
		res.valid  = acc && is_end;
		res.status = rstl_pkg::ST_OK;
		res.rtype  = '0;
		if (pend_q != rstl_pkg::ST_OK) begin
			res.status = pend_q;
		end else if (op == rstl_pkg::OP_INS_END) begin
			if (at_root ? root_type_q.typed : cur_type_q.typed) begin
				res.status = rstl_pkg::ST_TYPED;
			end
		end else if (best_q.typed) begin
			res.rtype = best_q.tid;
		end else if (root_type_q.typed) begin
			res.rtype = root_type_q.tid;
		end else begin
			res.status = rstl_pkg::ST_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rstl_pkg::S_CLEAR;
			clr_q       <= '0;
			cursor_q    <= '0;
			cur_type_q  <= '0;
			slot_q      <= '0;
			best_q      <= '0;
			stopped_q   <= 1'b0;
			pend_q      <= rstl_pkg::ST_OK;
			root_type_q <= '0;
			niu_q       <= rstl_pkg::CNT_W'(1);
		end else begin
			state_q <= state_d;
			if (state_q == rstl_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (acc && is_end) begin
				cursor_q  <= '0;
				best_q    <= '0;
				stopped_q <= 1'b0;
				pend_q    <= rstl_pkg::ST_OK;
				if (op == rstl_pkg::OP_INS_END && pend_q == rstl_pkg::ST_OK && at_root
				    && !root_type_q.typed) begin
					root_type_q <= {1'b1, type_id};
				end
			end
			if (acc && !is_end && !skip && !fold.valid) begin
				pend_q <= rstl_pkg::ST_INVALID;
			end
			if (state_q == rstl_pkg::S_READ) begin
				if (op_s1 == rstl_pkg::OP_INS_CHAR) begin
					if (miss) begin
						if (full) begin
							pend_q <= rstl_pkg::ST_FULL;
						end else begin
							cursor_q   <= niu_q[rstl_pkg::NODE_W-1:0];
							cur_type_q <= '0;
							slot_q     <= slot_s1;
							niu_q      <= niu_q + 1'b1;
						end
					end else begin
						cursor_q   <= mem_rd.child;
						cur_type_q <= mem_rd.typ;
						slot_q     <= slot_s1;
					end
				end else begin
					if (miss) begin
						stopped_q <= 1'b1;
					end else begin
						cursor_q   <= mem_rd.child;
						cur_type_q <= mem_rd.typ;
						slot_q     <= slot_s1;
						if (mem_rd.typ.typed) begin
							best_q <= mem_rd.typ;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_go) begin
			op_s1   <= op;
			slot_s1 <= slot_new;
		end
	end

endmodule

FILE: hw/rtl/reverse_suffix_trie_lookup.sv
// ----------------------------------------------------------------------------
// reverse_suffix_trie_lookup - longest-suffix type lookup over a node pool
// Characters of a name arrive last to first; end words return one result.
// ----------------------------------------------------------------------------
// Usage:
//  - cmd channel (cmd_valid/cmd_ready) takes one word per character or end
//    step: operation, character, type_id.
//  - rsp channel (rsp_valid/rsp_ready) returns status and result_type, one
//    word per insert end or lookup end; character words return nothing.
//  - A character word issues the child-table read in its accept cycle; the
//    next cycle consumes the read data, takes no new word and, on an insert
//    miss, writes back a new link over the single child-table port. Ignored
//    words (pending error, stopped lookup, bad character) issue no read.
//  - An end word's result sits in the output register the cycle after
//    accept.
//  - After reset the child table is cleared one entry per cycle, all 37888
//    entries (node count times alphabet size); cmd_ready stays low meanwhile.
//  - While a result waits for rsp_ready, character words are still taken;
//    an end word waits until the output register can be reloaded.
// ----------------------------------------------------------------------------
module reverse_suffix_trie_lookup (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  logic [1:0] operation,
	input  logic [7:0] character,
	input  logic [7:0] type_id,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [2:0] status,
	output logic [7:0] result_type
);

	rstl_pkg::res_t     res;
	rstl_pkg::mem_req_t mem_req;
	rstl_pkg::entry_t   mem_rd;
	logic               out_free;
	logic               rsp_valid_q;
	logic [2:0]         status_q;
	logic [7:0]         result_type_q;

	assign out_free = !rsp_valid_q || rsp_ready;

	rstl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.operation (operation),
		.character (character),
		.type_id   (type_id),
		.out_free  (out_free),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rd    (mem_rd)
	);

	rstl_ram #(
		.WIDTH ($bits(rstl_pkg::entry_t)),
		.DEPTH (rstl_pkg::SLOT_COUNT)
	) u_child_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res.valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			status_q      <= res.status;
			result_type_q <= res.rtype;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign result_type = result_type_q;

	// a result is only produced when the output register can take it
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("result produced while output register busy");

	// every accepted end word shows up on the response side next cycle
	a_end_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready
		 && (operation == rstl_pkg::OP_INS_END || operation == rstl_pkg::OP_LK_END))
		|=> rsp_valid)
		else $error("end word without response");

	// only an ok word carries a type
	a_type_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != rstl_pkg::ST_OK) |-> (result_type == '0))
		else $error("nonzero result_type with error status");

	// no table write lands in the cycle that consumes read data for a lookup
	a_lookup_ro: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd_valid && cmd_ready && operation == rstl_pkg::OP_LK_CHAR) && !cmd_ready
		|-> !mem_req.we)
		else $error("child table written during lookup walk");

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for reverse_suffix_trie_lookup
// Feeds insert and lookup walks character by character, last character first,
// and keeps its own copy of the trie to predict each end-word result. Covers
// case folding, digits and dot, longest typed suffix, the root default, bad
// characters, stopped lookups, re-typing and shared walks,
// under random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int WATCHDOG_LIMIT = 120000;
	localparam int KNOWN_MAX      = 48;
	localparam int KNOWN_LEN      = 16;

	typedef struct packed {
		rstl_pkg::status_t           st;
		logic [rstl_pkg::TYPE_W-1:0] rt;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_ready;
	logic [1:0] operation = 2'd0;
	logic [7:0] character = 8'd0;
	logic [7:0] type_id = 8'd0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	logic [2:0] status;
	logic [7:0] result_type;

	always #1 clk = ~clk;

	reverse_suffix_trie_lookup uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.operation   (operation),
		.character   (character),
		.type_id     (type_id),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.result_type (result_type)
	);

	// trie mirror
	int                trie_child [rstl_pkg::SLOT_COUNT];
	logic [8:0]        node_tag [rstl_pkg::NODE_COUNT];
	int                nodes_used;
	int                walk_node;
	logic [8:0]        best_tag;
	logic              walk_halted;
	rstl_pkg::status_t walk_err;

	verdict_t   verdicts [$];
	int         status_tally [5];
	int         words_sent = 0;
	int         results_checked = 0;
	int         fail_count = 0;
	int         quiet_cycles = 0;

	int         idle_pct = 0;
	int         stall_pct = 0;
	int         hold_len = 0;
	int         hold_seq = 0;
	int         hold_seen = 0;
	int         hold_left = 0;

	logic [7:0] name_buf [$];
	logic [7:0] known_chr [KNOWN_MAX][KNOWN_LEN];
	int         known_len [KNOWN_MAX];
	int         known_cnt = 0;
	int         small_codes [6] = '{0, 1, 2, 26, 27, 36};

	function automatic int sym_code(logic [7:0] c);
		if (c >= 8'h61 && c <= 8'h7a) return int'(c) - 'h61;
		if (c >= 8'h41 && c <= 8'h5a) return int'(c) - 'h41;
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + rstl_pkg::LETTER_COUNT;
		if (c == 8'h2e) return rstl_pkg::DOT_CODE;
		return -1;
	endfunction

	function automatic void clear_walk();
		walk_node   = 0;
		best_tag    = '0;
		walk_halted = 1'b0;
		walk_err    = rstl_pkg::ST_OK;
	endfunction

	function automatic void clear_trie();
		foreach (trie_child[i]) trie_child[i] = 0;
		foreach (node_tag[i]) node_tag[i] = '0;
		nodes_used = 1;
		clear_walk();
	endfunction

	// advance the mirror by one accepted word; end words queue their result
	function automatic void predict_word(rstl_pkg::op_t op, logic [7:0] ch, logic [7:0] tid);
		int       code;
		int       slot;
		verdict_t v;
		if (op == rstl_pkg::OP_INS_CHAR || op == rstl_pkg::OP_LK_CHAR) begin
			if (walk_err != rstl_pkg::ST_OK || (op == rstl_pkg::OP_LK_CHAR && walk_halted))
				return;
			code = sym_code(ch);
			if (code < 0) begin
				walk_err = rstl_pkg::ST_INVALID;
				return;
			end
			slot = walk_node * rstl_pkg::ALPHABET_SIZE + code;
			if (op == rstl_pkg::OP_INS_CHAR) begin
				if (trie_child[slot] == 0) begin
					if (nodes_used >= rstl_pkg::NODE_COUNT) begin
						walk_err = rstl_pkg::ST_FULL;
						return;
					end
					trie_child[slot] = nodes_used;
					nodes_used++;
				end
				walk_node = trie_child[slot];
			end else begin
				if (trie_child[slot] == 0) begin
					walk_halted = 1'b1;
					return;
				end
				walk_node = trie_child[slot];
				if (node_tag[walk_node][8]) best_tag = node_tag[walk_node];
			end
			return;
		end
		v.st = rstl_pkg::ST_OK;
		v.rt = '0;
		if (walk_err != rstl_pkg::ST_OK) begin
			v.st = walk_err;
		end else if (op == rstl_pkg::OP_INS_END) begin
			if (node_tag[walk_node][8]) v.st = rstl_pkg::ST_TYPED;
			else node_tag[walk_node] = {1'b1, tid};
		end else if (best_tag[8]) begin
			v.rt = best_tag[7:0];
		end else if (node_tag[0][8]) begin
			v.rt = node_tag[0][7:0];
		end else begin
			v.st = rstl_pkg::ST_NONE;
		end
		status_tally[int'(v.st)]++;
		verdicts.push_back(v);
		clear_walk();
	endfunction

	task automatic send_word(rstl_pkg::op_t op, logic [7:0] ch, logic [7:0] tid);
		while ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		operation <= op;
		character <= ch;
		type_id   <= tid;
		do @(posedge clk); while (cmd_ready !== 1'b1);
		predict_word(op, ch, tid);
		words_sent++;
	endtask

	// walks name_buf last character first, then the end word
	task automatic send_name(bit lookup, logic [7:0] tid);
		for (int i = name_buf.size() - 1; i >= 0; i--)
			send_word(lookup ? rstl_pkg::OP_LK_CHAR : rstl_pkg::OP_INS_CHAR, name_buf[i],
				8'($urandom_range(255)));
		send_word(lookup ? rstl_pkg::OP_LK_END : rstl_pkg::OP_INS_END,
			8'($urandom_range(255)), tid);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (verdicts.size() != 0);
	endtask

	function automatic void load_text(string s);
		name_buf = {};
		for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
	endfunction

	function automatic logic [7:0] pick_char(bit wide);
		logic [7:0] c;
		int         code;
		if ($urandom_range(99) < 4) begin
			do c = 8'($urandom_range(255)); while (sym_code(c) >= 0);
			return c;
		end
		code = wide ? $urandom_range(rstl_pkg::ALPHABET_SIZE - 1)
		            : small_codes[$urandom_range(5)];
		if (code < rstl_pkg::LETTER_COUNT) return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(code);
		if (code < rstl_pkg::DOT_CODE) return 8'h30 + 8'(code - rstl_pkg::LETTER_COUNT);
		return 8'h2e;
	endfunction

	function automatic void remember_name();
		int k;
		if (name_buf.size() > KNOWN_LEN) return;
		if (known_cnt < KNOWN_MAX) begin
			k = known_cnt;
			known_cnt++;
		end else begin
			k = $urandom_range(KNOWN_MAX - 1);
		end
		known_len[k] = name_buf.size();
		foreach (name_buf[i]) known_chr[k][i] = name_buf[i];
	endfunction

	task automatic test_basic_walks();
		idle_pct  = 0;
		stall_pct = 0;
		name_buf = {};
		send_name(1, 8'h00);            // empty trie, untyped root
		load_text("z.9A");
		send_name(0, 8'hFF);
		load_text("x0Z.9a");            // case folds onto the same path, stops at '0'
		send_name(1, 8'h00);
	endtask

	task automatic test_walk_errors();
		name_buf = {8'h63, 8'hFF, 8'h62};   // bad byte mid insert, rest ignored
		send_name(0, 8'h11);
		name_buf = {8'h00, 8'h71};          // miss, then a bad byte that is ignored
		send_name(1, 8'h22);
		name_buf = {8'h80};
		send_name(1, 8'h33);
		// both kinds share one walk
		send_word(rstl_pkg::OP_INS_CHAR, 8'h61, 8'h44);
		send_word(rstl_pkg::OP_LK_END, 8'h61, 8'h55);
		name_buf = {};
		send_name(0, 8'h00);            // types the root
		send_name(0, 8'h07);            // root already typed
		load_text("q");
		send_name(1, 8'h5A);            // falls back to the root default
	endtask

	task automatic test_random_traffic(int n_words, int idle, int stall, bit wide);
		int stop_at;
		int roll;
		int k;
		idle_pct  = idle;
		stall_pct = stall;
		stop_at   = words_sent + n_words;
		while (words_sent < stop_at) begin
			roll = $urandom_range(99);
			name_buf = {};
			if (roll < 40) begin
				repeat (($urandom_range(29) == 0) ? 0 : $urandom_range(1, 6))
					name_buf.push_back(pick_char(wide));
				send_name(0, 8'($urandom_range(255)));
				remember_name();
			end else if (roll < 88) begin
				if (known_cnt > 0 && $urandom_range(3) != 0) begin
					k = $urandom_range(known_cnt - 1);
					for (int i = 0; i < known_len[k]; i++) name_buf.push_back(known_chr[k][i]);
					// leading characters go deeper than the known suffix
					repeat ($urandom_range(3)) name_buf.push_front(pick_char(wide));
				end else begin
					repeat ($urandom_range(1, 6)) name_buf.push_back(pick_char(wide));
				end
				send_name(1, 8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(1, 4))
					send_word(rstl_pkg::op_t'($urandom_range(3)), 8'($urandom_range(255)),
						8'($urandom_range(255)));
			end
		end
	endtask

	task automatic test_backpressure();
		idle_pct  = 0;
		stall_pct = 0;
		hold_len  = 300;
		hold_seq++;
		for (int n = 0; n < 8; n++) begin
			name_buf = {};
			repeat ($urandom_range(1, 4)) name_buf.push_back(pick_char(0));
			send_name(n[0], 8'($urandom_range(255)));
		end
		wait_drained();
	endtask

	// receiver: random stalls plus a long hold-off when requested
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			if (verdicts.size() == 0) begin
				$error("unexpected result word: status %0d, result_type %0d",
					status, result_type);
				fail_count++;
			end else begin
				want = verdicts.pop_front();
				results_checked++;
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					fail_count++;
				end
				if (result_type !== want.rt) begin
					$error("result_type: expected %0d, got %0d", want.rt, result_type);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid === 1'b1 && cmd_ready === 1'b1) ||
			(rsp_valid === 1'b1 && rsp_ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timed out with %0d results outstanding", verdicts.size());
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clear_trie();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_walks();
		test_walk_errors();
		test_random_traffic(150, 0, 0, 0);
		test_random_traffic(150, 63, 0, 0);
		test_random_traffic(150, 0, 63, 0);
		test_backpressure();
		test_random_traffic(130, 28, 28, 1);
		wait_drained();
		repeat (10) @(posedge clk);
		$display("sent %0d words, checked %0d results, trie grew to %0d of %0d nodes",
			words_sent, results_checked, nodes_used, rstl_pkg::NODE_COUNT);
		$display("statuses seen: ok %0d, invalid %0d, typed %0d, full %0d, none %0d",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3],
			status_tally[4]);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
